// File: hw/rtl/frt_pkg.sv
// frt_pkg: shared types and constants of the fragment reassembly tracker.
// No dependencies; imported by the compare unit, the tracker, the checker and the bench.
package frt_pkg;

	localparam int MAX_SLOTS    = 16;
	localparam int MAX_FRAGS    = 32;
	localparam int HEADER_BYTES = 24;
	localparam int SLOT_W       = $clog2(MAX_SLOTS);
	localparam int FRAG_W       = $clog2(MAX_FRAGS);
	localparam int LEN_DEPTH    = MAX_SLOTS * MAX_FRAGS;
	localparam int LEN_AW       = SLOT_W + FRAG_W;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_SLOTS - 1);

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_WIRE_VERSION = 2'd0,
		CFG_KEY_FLAG_MASK = 2'd1,
		CFG_TIMEOUT_LIMIT = 2'd2,
		CFG_PENDING_LIMIT = 2'd3
	} cfg_idx_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DROP = 2'd0,
		STAT_INCOMPLETE = 2'd1,
		STAT_READY = 2'd2,
		STAT_SWEEP = 2'd3
	} status_t;

	// shared compare unit operations
	typedef enum logic [1:0] {
		CMP_EQ = 2'd0,
		CMP_LESS = 2'd1,
		CMP_AGE = 2'd2
	} cmp_op_t;

	typedef struct packed {
		cmp_op_t     op;
		logic [63:0] x64;
		logic [63:0] y64;
		logic [31:0] x32;
		logic [31:0] y32;
	} cmp_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_FIND,
		S_FIND_END,
		S_EVICT,
		S_EVICT_END,
		S_ALLOC,
		S_UPDATE,
		S_SWEEP,
		S_RESP,
		S_RD,
		S_LD
	} state_t;

endpackage

// File: hw/rtl/frt_if.sv
// frt_if: valid/ready channel interfaces for header input and results.
// Depends on frt_pkg for nothing but is compiled after it.
interface frt_hdr_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  hdr_version;
	logic [7:0]  frame_type;
	logic [15:0] hdr_flags;
	logic [15:0] stream_num;
	logic [15:0] total_frags;
	logic [31:0] frame_num;
	logic [15:0] frag_num;
	logic [15:0] payload_bytes;
	logic [63:0] capture_time_us;
	logic [15:0] datagram_bytes;
	logic [63:0] now_time_us;

	modport source (output valid, cmd, hdr_version, frame_type, hdr_flags, stream_num,
		total_frags, frame_num, frag_num, payload_bytes, capture_time_us, datagram_bytes,
		now_time_us, input ready);
	modport sink (input valid, cmd, hdr_version, frame_type, hdr_flags, stream_num,
		total_frags, frame_num, frag_num, payload_bytes, capture_time_us, datagram_bytes,
		now_time_us, output ready);
endinterface

interface frt_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  out_frame_type;
	logic        key_frame;
	logic [15:0] out_stream;
	logic [31:0] out_frame;
	logic [63:0] out_capture_time;
	logic [5:0]  out_frag_total;
	logic [15:0] frag_length;
	logic        last;
	logic [31:0] dropped_total;
	logic [31:0] completed_total;
	logic [31:0] timed_out_total;

	modport source (output valid, status, out_frame_type, key_frame, out_stream, out_frame,
		out_capture_time, out_frag_total, frag_length, last, dropped_total, completed_total,
		timed_out_total, input ready);
	modport sink (input valid, status, out_frame_type, key_frame, out_stream, out_frame,
		out_capture_time, out_frag_total, frag_length, last, dropped_total, completed_total,
		timed_out_total, output ready);
endinterface

// File: hw/rtl/frt_ram.sv
// frt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module frt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hw/rtl/frt_cmp_unit.sv
// frt_cmp_unit: shared compare unit used by the slot scans (match, oldest, age).
// Depends on frt_pkg.
module frt_cmp_unit import frt_pkg::*; (
	input  cmp_req_t req,
	output logic     hit
);
	logic [63:0] diff;

	always_comb begin
		diff = req.x64 - req.y64;
		case (req.op)
			CMP_EQ:   hit = (req.x32 == req.y32);
			CMP_LESS: hit = (req.x64 < req.y64) || ((req.x64 == req.y64) && (req.x32 < req.y32));
			CMP_AGE:  hit = (diff > {32'd0, req.x32});
			default:  hit = 1'b0;
		endcase
	end
endmodule

// File: hw/rtl/fragment_reassembly_tracker.sv
// fragment_reassembly_tracker: pending-frame table with a scan sequencer.
// Depends on frt_pkg, frt_if, frt_ram and frt_cmp_unit.
// Each scan (find, eviction pass, sweep) steps one slot a cycle through the shared compare
// unit; a completed frame then emits one result per fragment, each through a length RAM read
// (S_RD) and a result load (S_LD) that waits while the result register is stalled.
// One transaction in work at a time; reset clears valid bits, counters, config to defaults.
module fragment_reassembly_tracker import frt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	frt_hdr_if.sink     hdr,
	frt_res_if.source   res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	state_t state_q, state_d;

	// configuration
	logic [7:0]  wire_version_q;
	logic [15:0] key_mask_q;
	logic [31:0] timeout_q;
	logic [4:0]  plimit_q;
	logic [4:0]  lim;

	// captured header
	logic [7:0]  ver_q, type_q;
	logic [15:0] flags_q, stream_q, tot_q, fidx_q, plen_q, dlen_q;
	logic [31:0] frame_q;
	logic [63:0] cap_q, now_q;

	// slot table
	logic [MAX_SLOTS-1:0] valid_q;
	logic [31:0] s_frame_q [MAX_SLOTS];
	logic [7:0]  s_type_q [MAX_SLOTS];
	logic [15:0] s_flags_q [MAX_SLOTS];
	logic [15:0] s_stream_q [MAX_SLOTS];
	logic [5:0]  s_tot_q [MAX_SLOTS];
	logic [5:0]  s_recv_q [MAX_SLOTS];
	logic [63:0] s_cap_q [MAX_SLOTS];
	logic [63:0] s_arr_q [MAX_SLOTS];
	logic [MAX_FRAGS-1:0] s_map_q [MAX_SLOTS];

	// scan state
	logic [SLOT_W-1:0] idx_q, s_q, free_q, best_q;
	logic              hit_q, free_found_q, best_found_q;
	logic [4:0]        cnt_q;
	logic [63:0]       barr_q;
	logic [31:0]       bfr_q;
	logic [FRAG_W-1:0] k_q;
	status_t           stat_q;

	logic [31:0] drop_cnt_q, comp_cnt_q, tout_cnt_q;

	// output register
	logic        ovalid_q;
	status_t     ostat_q;
	logic [7:0]  otype_q;
	logic        okey_q;
	logic [15:0] ostream_q;
	logic [31:0] oframe_q;
	logic [63:0] ocap_q;
	logic [5:0]  otot_q;
	logic [15:0] olen_q;
	logic        olast_q;
	logic [31:0] odrop_q, ocomp_q, otout_q;

	logic        out_free, in_acc, chk_drop, dup, mismatch, done_frag, k_last;
	logic [16:0] need_len;
	cmp_req_t    creq;
	logic        chit;
	logic        ram_we, ram_re;
	logic [LEN_AW-1:0] ram_waddr, ram_raddr;
	logic [15:0] ram_rdata;

	frt_cmp_unit u_cmp (.req(creq), .hit(chit));

	frt_ram #(.WIDTH(16), .DEPTH(LEN_DEPTH)) u_len_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(plen_q),
		.re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
	);

	// derived conditions
	always_comb begin
		lim = (plimit_q == 5'd0) ? 5'd1 :
			(plimit_q > 5'(MAX_SLOTS)) ? 5'(MAX_SLOTS) : plimit_q;
		need_len = 17'(HEADER_BYTES) + {1'b0, plen_q};
		chk_drop = (dlen_q < 16'(HEADER_BYTES)) || (ver_q != wire_version_q) ||
			(tot_q == 16'd0) || (fidx_q >= tot_q) || (tot_q > 16'(MAX_FRAGS)) ||
			(need_len > {1'b0, dlen_q});
		mismatch  = ({10'd0, s_tot_q[s_q]} != tot_q);
		dup       = s_map_q[s_q][fidx_q[FRAG_W-1:0]];
		done_frag = ((s_recv_q[s_q] + 6'd1) == s_tot_q[s_q]);
		k_last    = (({1'b0, k_q} + 6'd1) == s_tot_q[s_q]);
		out_free  = !ovalid_q || res.ready;
		in_acc    = hdr.valid && hdr.ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (hdr.valid) state_d = hdr.cmd ? S_SWEEP : S_CHECK;
			S_CHECK:     state_d = chk_drop ? S_RESP : S_FIND;
			S_FIND:      if (idx_q == SLOT_LAST) state_d = S_FIND_END;
			S_FIND_END: begin
				if (hit_q) state_d = mismatch ? S_RESP : S_UPDATE;
				else state_d = (cnt_q > lim) ? S_EVICT : S_ALLOC;
			end
			S_EVICT:     if (idx_q == SLOT_LAST) state_d = S_EVICT_END;
			S_EVICT_END: begin
				if (!best_found_q) state_d = S_RESP;
				else state_d = ((cnt_q - 5'd1) > lim) ? S_EVICT : S_ALLOC;
			end
			S_ALLOC:     state_d = free_found_q ? S_UPDATE : S_RESP;
			S_UPDATE:    state_d = (!dup && done_frag) ? S_RD : S_RESP;
			S_SWEEP:     if (idx_q == SLOT_LAST) state_d = S_RESP;
			S_RESP:      if (out_free) state_d = S_IDLE;
			S_RD:        state_d = S_LD;
			S_LD:        if (out_free) state_d = k_last ? S_IDLE : S_RD;
			default:     state_d = S_IDLE;
		endcase
	end

	// outputs: handshake, compare requests, RAM controls
	always_comb begin
		hdr.ready = (state_q == S_IDLE);
		creq = '{op: CMP_EQ, x64: 64'd0, y64: 64'd0, x32: s_frame_q[idx_q], y32: frame_q};
		case (state_q)
			S_EVICT: creq = '{op: CMP_LESS, x64: s_arr_q[idx_q], y64: barr_q,
				x32: s_frame_q[idx_q], y32: bfr_q};
			S_SWEEP: creq = '{op: CMP_AGE, x64: now_q, y64: s_arr_q[idx_q],
				x32: timeout_q, y32: 32'd0};
			default: ;
		endcase
		ram_we    = (state_q == S_UPDATE) && !dup;
		ram_waddr = {s_q, fidx_q[FRAG_W-1:0]};
		ram_re    = (state_q == S_RD);
		ram_raddr = {s_q, k_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_version_q <= 8'd1;
			key_mask_q     <= 16'd1;
			timeout_q      <= 32'd500000;
			plimit_q       <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIRE_VERSION:  wire_version_q <= cfg_data[7:0];
				CFG_KEY_FLAG_MASK: key_mask_q <= cfg_data[15:0];
				CFG_TIMEOUT_LIMIT: timeout_q <= cfg_data;
				CFG_PENDING_LIMIT: plimit_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// header capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ver_q    <= hdr.hdr_version;
			type_q   <= hdr.frame_type;
			flags_q  <= hdr.hdr_flags;
			stream_q <= hdr.stream_num;
			tot_q    <= hdr.total_frags;
			frame_q  <= hdr.frame_num;
			fidx_q   <= hdr.frag_num;
			plen_q   <= hdr.payload_bytes;
			cap_q    <= hdr.capture_time_us;
			dlen_q   <= hdr.datagram_bytes;
			now_q    <= hdr.now_time_us;
		end
	end

	// sequencer control state, valid bits and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			idx_q        <= '0;
			s_q          <= '0;
			free_q       <= '0;
			best_q       <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			cnt_q        <= '0;
			k_q          <= '0;
			stat_q       <= STAT_DROP;
			drop_cnt_q   <= '0;
			comp_cnt_q   <= '0;
			tout_cnt_q   <= '0;
			barr_q       <= '0;
			bfr_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: idx_q <= '0;
				S_CHECK: begin
					hit_q        <= 1'b0;
					free_found_q <= 1'b0;
					cnt_q        <= 5'd1;
					if (chk_drop) begin
						drop_cnt_q <= drop_cnt_q + 32'd1;
						stat_q     <= STAT_DROP;
					end
				end
				S_FIND: begin
					idx_q <= idx_q + SLOT_W'(1);
					cnt_q <= cnt_q + {4'd0, valid_q[idx_q]};
					if (valid_q[idx_q] && chit && !hit_q) begin
						hit_q <= 1'b1;
						s_q   <= idx_q;
					end
					if (!valid_q[idx_q] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= idx_q;
					end
				end
				S_FIND_END: begin
					idx_q        <= '0;
					best_found_q <= 1'b0;
					barr_q       <= now_q;
					bfr_q        <= frame_q;
					if (hit_q && mismatch) begin
						valid_q[s_q] <= 1'b0;
						drop_cnt_q   <= drop_cnt_q + 32'd1;
						stat_q       <= STAT_DROP;
					end
				end
				S_EVICT: begin
					idx_q <= idx_q + SLOT_W'(1);
					if (valid_q[idx_q] && chit) begin
						best_found_q <= 1'b1;
						best_q       <= idx_q;
						barr_q       <= s_arr_q[idx_q];
						bfr_q        <= s_frame_q[idx_q];
					end
				end
				S_EVICT_END: begin
					drop_cnt_q   <= drop_cnt_q + 32'd1;
					stat_q       <= STAT_DROP;
					idx_q        <= '0;
					best_found_q <= 1'b0;
					barr_q       <= now_q;
					bfr_q        <= frame_q;
					if (best_found_q) begin
						valid_q[best_q] <= 1'b0;
						cnt_q           <= cnt_q - 5'd1;
						if (!free_found_q || best_q < free_q) begin
							free_q       <= best_q;
							free_found_q <= 1'b1;
						end
					end
				end
				S_ALLOC: begin
					if (free_found_q) begin
						s_q             <= free_q;
						valid_q[free_q] <= 1'b1;
					end else begin
						drop_cnt_q <= drop_cnt_q + 32'd1;
						stat_q     <= STAT_DROP;
					end
				end
				S_UPDATE: begin
					stat_q <= STAT_INCOMPLETE;
					k_q    <= '0;
					if (!dup && done_frag) begin
						valid_q[s_q] <= 1'b0;
						comp_cnt_q   <= comp_cnt_q + 32'd1;
					end
				end
				S_SWEEP: begin
					idx_q  <= idx_q + SLOT_W'(1);
					stat_q <= STAT_SWEEP;
					if (valid_q[idx_q] && chit) begin
						valid_q[idx_q] <= 1'b0;
						tout_cnt_q     <= tout_cnt_q + 32'd1;
					end
				end
				S_LD: if (out_free) k_q <= k_q + FRAG_W'(1);
				default: ;
			endcase
		end
	end

	// slot payload fields
	always_ff @(posedge clk) begin
		if (state_q == S_ALLOC && free_found_q) begin
			s_frame_q[free_q]  <= frame_q;
			s_type_q[free_q]   <= type_q;
			s_flags_q[free_q]  <= flags_q;
			s_stream_q[free_q] <= stream_q;
			s_tot_q[free_q]    <= tot_q[5:0];
			s_recv_q[free_q]   <= '0;
			s_cap_q[free_q]    <= cap_q;
			s_arr_q[free_q]    <= now_q;
			s_map_q[free_q]    <= '0;
		end
		if (state_q == S_UPDATE && !dup) begin
			s_map_q[s_q][fidx_q[FRAG_W-1:0]] <= 1'b1;
			s_recv_q[s_q]  <= s_recv_q[s_q] + 6'd1;
			s_flags_q[s_q] <= s_flags_q[s_q] | (flags_q & key_mask_q);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_free) begin
			ovalid_q <= (state_q == S_RESP) || (state_q == S_LD);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == S_RESP) begin
			ostat_q   <= stat_q;
			otype_q   <= '0;
			okey_q    <= 1'b0;
			ostream_q <= '0;
			oframe_q  <= '0;
			ocap_q    <= '0;
			otot_q    <= '0;
			olen_q    <= '0;
			olast_q   <= 1'b1;
			odrop_q   <= drop_cnt_q;
			ocomp_q   <= comp_cnt_q;
			otout_q   <= tout_cnt_q;
		end else if (out_free && state_q == S_LD) begin
			ostat_q   <= STAT_READY;
			otype_q   <= s_type_q[s_q];
			okey_q    <= |(s_flags_q[s_q] & key_mask_q);
			ostream_q <= s_stream_q[s_q];
			oframe_q  <= s_frame_q[s_q];
			ocap_q    <= s_cap_q[s_q];
			otot_q    <= s_tot_q[s_q];
			olen_q    <= ram_rdata;
			olast_q   <= k_last;
			odrop_q   <= drop_cnt_q;
			ocomp_q   <= comp_cnt_q;
			otout_q   <= tout_cnt_q;
		end
	end

	assign res.valid            = ovalid_q;
	assign res.status           = ostat_q;
	assign res.out_frame_type   = otype_q;
	assign res.key_frame        = okey_q;
	assign res.out_stream       = ostream_q;
	assign res.out_frame        = oframe_q;
	assign res.out_capture_time = ocap_q;
	assign res.out_frag_total   = otot_q;
	assign res.frag_length      = olen_q;
	assign res.last             = olast_q;
	assign res.dropped_total    = odrop_q;
	assign res.completed_total  = ocomp_q;
	assign res.timed_out_total  = otout_q;
endmodule

// File: hw/rtl/frt_checker.sv
// frt_checker: port-level assertions of the fragment reassembly tracker, with its bind.
// Depends on frt_pkg and the top level's ports.
module frt_checker import frt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_status,
	input logic        out_last,
	input logic [15:0] out_len,
	input logic [31:0] out_frame
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_last))
		else $error("result changed while stalled");

	// only frame-ready results may be followed by more results of the same transaction
	a_simple_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != STAT_READY) |-> out_last)
		else $error("non-ready result without last");

	// length and frame fields of a non-ready result are zero
	a_simple_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != STAT_READY) |-> (out_len == 16'd0) && (out_frame == 32'd0))
		else $error("non-ready result carries frame data");

	// the block is busy right after taking a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accept");
endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(hdr.valid), .in_ready(hdr.ready),
	.out_valid(res.valid), .out_ready(res.ready),
	.out_status(res.status), .out_last(res.last),
	.out_len(res.frag_length), .out_frame(res.out_frame)
);

// File: bench/tb_fragment_reassembly_tracker.sv
// tb_fragment_reassembly_tracker: self-checking bench for the fragment reassembly tracker.
// Depends on frt_pkg, frt_if and the tracker RTL; a scoreboard class predicts every result
// transaction from the accepted header transactions and the register settings.
`timescale 1ns / 1ps

import frt_pkg::*;

typedef struct {
	logic        cmd;
	logic [7:0]  hdr_version;
	logic [7:0]  frame_type;
	logic [15:0] hdr_flags;
	logic [15:0] stream_num;
	logic [15:0] total_frags;
	logic [31:0] frame_num;
	logic [15:0] frag_num;
	logic [15:0] payload_bytes;
	logic [63:0] capture_time_us;
	logic [15:0] datagram_bytes;
	logic [63:0] now_time_us;
} frag_hdr_t;

typedef struct {
	status_t     status;
	logic [7:0]  frame_type;
	logic        key;
	logic [15:0] stream;
	logic [31:0] frame;
	logic [63:0] capture;
	logic [5:0]  frag_total;
	logic [15:0] frag_len;
	logic        last;
	logic [31:0] drops;
	logic [31:0] completes;
	logic [31:0] timeouts;
} frag_res_t;

class frt_scoreboard;
	// register copies
	logic [7:0]  wire_ver;
	logic [15:0] key_mask;
	logic [31:0] tmo_limit;
	logic [4:0]  pend_limit;
	// pending frame table
	bit          busy[MAX_SLOTS];
	logic [31:0] fr_id[MAX_SLOTS];
	logic [7:0]  fr_type[MAX_SLOTS];
	logic [15:0] fr_flags[MAX_SLOTS];
	logic [15:0] fr_stream[MAX_SLOTS];
	int          fr_total[MAX_SLOTS];
	int          fr_got[MAX_SLOTS];
	logic [63:0] fr_capture[MAX_SLOTS];
	logic [63:0] fr_arrival[MAX_SLOTS];
	logic [31:0] fr_map[MAX_SLOTS];
	logic [15:0] fr_len[MAX_SLOTS][MAX_FRAGS];
	logic [31:0] n_drop, n_done, n_tmo;
	frag_res_t   pending_res[$];
	int          errors;

	function new();
		wire_ver = 8'd1;
		key_mask = 16'd1;
		tmo_limit = 32'd500000;
		pend_limit = 5'd16;
		foreach (busy[i]) busy[i] = 0;
		n_drop = 0;
		n_done = 0;
		n_tmo = 0;
		errors = 0;
	endfunction

	function void set_reg(cfg_idx_t idx, logic [31:0] v);
		case (idx)
			CFG_WIRE_VERSION: wire_ver = v[7:0];
			CFG_KEY_FLAG_MASK: key_mask = v[15:0];
			CFG_TIMEOUT_LIMIT: tmo_limit = v;
			CFG_PENDING_LIMIT: pend_limit = v[4:0];
			default: ;
		endcase
	endfunction

	function void push_plain(status_t st);
		frag_res_t r;
		r = '{status: st, frame_type: 0, key: 0, stream: 0, frame: 0, capture: 0,
			frag_total: 0, frag_len: 0, last: 1, drops: n_drop, completes: n_done,
			timeouts: n_tmo};
		pending_res.push_back(r);
	endfunction

	// predict the results of one accepted header transaction
	function void note_input(frag_hdr_t h);
		int s, k, lim, cnt, best, tot, idx;
		logic [63:0] barr;
		logic [31:0] bfr;
		frag_res_t r;
		tot = h.total_frags;
		idx = h.frag_num;
		if (h.cmd) begin
			for (k = 0; k < MAX_SLOTS; k++)
				if (busy[k] && (h.now_time_us - fr_arrival[k]) > {32'd0, tmo_limit}) begin
					busy[k] = 0;
					n_tmo++;
				end
			push_plain(STAT_SWEEP);
			return;
		end
		if (h.datagram_bytes < HEADER_BYTES || h.hdr_version != wire_ver ||
				tot == 0 || idx >= tot || tot > MAX_FRAGS ||
				HEADER_BYTES + int'(h.payload_bytes) > int'(h.datagram_bytes)) begin
			n_drop++;
			push_plain(STAT_DROP);
			return;
		end
		s = -1;
		for (k = 0; k < MAX_SLOTS; k++)
			if (s < 0 && busy[k] && fr_id[k] == h.frame_num) s = k;
		if (s < 0) begin
			lim = (pend_limit == 0) ? 1 : (pend_limit > MAX_SLOTS) ? MAX_SLOTS : pend_limit;
			cnt = 1;
			for (k = 0; k < MAX_SLOTS; k++) if (busy[k]) cnt++;
			// evict oldest arrivals, the new frame competing too
			while (cnt > lim) begin
				best = -1;
				barr = h.now_time_us;
				bfr = h.frame_num;
				for (k = 0; k < MAX_SLOTS; k++)
					if (busy[k] && (fr_arrival[k] < barr ||
							(fr_arrival[k] == barr && fr_id[k] < bfr))) begin
						best = k;
						barr = fr_arrival[k];
						bfr = fr_id[k];
					end
				n_drop++;
				if (best < 0) begin
					push_plain(STAT_DROP);
					return;
				end
				busy[best] = 0;
				cnt--;
			end
			for (k = 0; k < MAX_SLOTS; k++) if (s < 0 && !busy[k]) s = k;
			if (s < 0) begin
				n_drop++;
				push_plain(STAT_DROP);
				return;
			end
			busy[s] = 1;
			fr_id[s] = h.frame_num;
			fr_type[s] = h.frame_type;
			fr_flags[s] = h.hdr_flags;
			fr_stream[s] = h.stream_num;
			fr_total[s] = tot;
			fr_got[s] = 0;
			fr_capture[s] = h.capture_time_us;
			fr_arrival[s] = h.now_time_us;
			fr_map[s] = 0;
		end else if (fr_total[s] != tot) begin
			busy[s] = 0;
			n_drop++;
			push_plain(STAT_DROP);
			return;
		end
		// duplicates are ignored
		if (fr_map[s][idx]) begin
			push_plain(STAT_INCOMPLETE);
			return;
		end
		fr_len[s][idx] = h.payload_bytes;
		fr_map[s][idx] = 1'b1;
		fr_got[s]++;
		fr_flags[s] = fr_flags[s] | (h.hdr_flags & key_mask);
		if (fr_got[s] != fr_total[s]) begin
			push_plain(STAT_INCOMPLETE);
			return;
		end
		busy[s] = 0;
		n_done++;
		for (k = 0; k < tot; k++) begin
			r = '{status: STAT_READY, frame_type: fr_type[s],
				key: (fr_flags[s] & key_mask) != 0, stream: fr_stream[s], frame: fr_id[s],
				capture: fr_capture[s], frag_total: tot[5:0], frag_len: fr_len[s][k],
				last: (k + 1 == tot), drops: n_drop, completes: n_done, timeouts: n_tmo};
			pending_res.push_back(r);
		end
	endfunction

	task report(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task check_result(frag_res_t g);
		frag_res_t e;
		if (pending_res.size() == 0) begin
			report("result transaction with nothing expected");
			return;
		end
		e = pending_res.pop_front();
		if (g.status !== e.status)
			report($sformatf("status %0d, expected %0d", g.status, e.status));
		if (g.frame_type !== e.frame_type)
			report($sformatf("out_frame_type %h, expected %h", g.frame_type, e.frame_type));
		if (g.key !== e.key)
			report($sformatf("key_frame %b, expected %b", g.key, e.key));
		if (g.stream !== e.stream)
			report($sformatf("out_stream %h, expected %h", g.stream, e.stream));
		if (g.frame !== e.frame)
			report($sformatf("out_frame %h, expected %h", g.frame, e.frame));
		if (g.capture !== e.capture)
			report($sformatf("out_capture_time %h, expected %h", g.capture, e.capture));
		if (g.frag_total !== e.frag_total)
			report($sformatf("out_frag_total %0d, expected %0d", g.frag_total, e.frag_total));
		if (g.frag_len !== e.frag_len)
			report($sformatf("frag_length %h, expected %h", g.frag_len, e.frag_len));
		if (g.last !== e.last)
			report($sformatf("last %b, expected %b", g.last, e.last));
		if (g.drops !== e.drops)
			report($sformatf("dropped_total %0d, expected %0d", g.drops, e.drops));
		if (g.completes !== e.completes)
			report($sformatf("completed_total %0d, expected %0d", g.completes, e.completes));
		if (g.timeouts !== e.timeouts)
			report($sformatf("timed_out_total %0d, expected %0d", g.timeouts, e.timeouts));
	endtask
endclass

module tb_fragment_reassembly_tracker;
	localparam int STALL_LIMIT = 6000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	frt_hdr_if hdr();
	frt_res_if res();

	fragment_reassembly_tracker uut (
		.clk(clk), .arst_n(arst_n), .hdr(hdr.sink), .res(res.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	frt_scoreboard sb = new();

	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_req;
	int          hold_left;
	int          quiet_cycles;
	int          sent;
	bit          offering;
	logic [7:0]  cur_ver;
	logic [63:0] clock_us;

	always #2 clk = ~clk;

	// result side backpressure, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else
			res.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// accepted transactions on both channels, plus the stall watchdog
	always @(posedge clk) begin
		frag_hdr_t h;
		frag_res_t r;
		if (arst_n) begin
			quiet_cycles++;
			if (hdr.valid && hdr.ready) begin
				h = '{hdr.cmd, hdr.hdr_version, hdr.frame_type, hdr.hdr_flags, hdr.stream_num,
					hdr.total_frags, hdr.frame_num, hdr.frag_num, hdr.payload_bytes,
					hdr.capture_time_us, hdr.datagram_bytes, hdr.now_time_us};
				sb.note_input(h);
				quiet_cycles = 0;
			end
			if (res.valid && res.ready) begin
				r = '{status_t'(res.status), res.out_frame_type, res.key_frame,
					res.out_stream, res.out_frame, res.out_capture_time, res.out_frag_total,
					res.frag_length, res.last, res.dropped_total, res.completed_total,
					res.timed_out_total};
				sb.check_result(r);
				quiet_cycles = 0;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task lower_valid();
		if (offering) begin
			hdr.valid <= 1'b0;
			offering = 0;
		end
	endtask

	// offer one header transaction and wait for it to be taken
	task send(frag_hdr_t h);
		hdr.cmd <= h.cmd;
		hdr.hdr_version <= h.hdr_version;
		hdr.frame_type <= h.frame_type;
		hdr.hdr_flags <= h.hdr_flags;
		hdr.stream_num <= h.stream_num;
		hdr.total_frags <= h.total_frags;
		hdr.frame_num <= h.frame_num;
		hdr.frag_num <= h.frag_num;
		hdr.payload_bytes <= h.payload_bytes;
		hdr.capture_time_us <= h.capture_time_us;
		hdr.datagram_bytes <= h.datagram_bytes;
		hdr.now_time_us <= h.now_time_us;
		hdr.valid <= 1'b1;
		offering = 1;
		do @(posedge clk); while (!hdr.ready);
		sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			lower_valid();
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// wait for every expected result, then let the block settle
	task drain();
		lower_valid();
		@(posedge clk);
		while (sb.pending_res.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task write_regs(logic [31:0] ver, logic [31:0] mask, logic [31:0] tmo, logic [31:0] lim);
		cfg_idx_t idx;
		logic [31:0] v;
		for (int i = 0; i < 4; i++) begin
			idx = cfg_idx_t'(i);
			v = (i == 0) ? ver : (i == 1) ? mask : (i == 2) ? tmo : lim;
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= v;
			@(posedge clk);
			sb.set_reg(idx, v);
		end
		cfg_we <= 1'b0;
		cur_ver = ver[7:0];
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// a well-formed fragment; time moves forward a little
	function automatic frag_hdr_t frag(logic [31:0] fr, int tot, int idx);
		frag_hdr_t h;
		logic [15:0] plen;
		plen = ($urandom_range(19) == 0) ? 16'd65511 : 16'($urandom_range(0, 200));
		clock_us += $urandom_range(1, 3000);
		h.cmd = 1'b0;
		h.hdr_version = cur_ver;
		h.frame_type = 8'($urandom);
		h.hdr_flags = 16'($urandom);
		h.stream_num = 16'($urandom);
		h.total_frags = 16'(tot);
		h.frame_num = fr;
		h.frag_num = 16'(idx);
		h.payload_bytes = plen;
		h.capture_time_us = rand64();
		h.datagram_bytes = (plen == 16'd65511) ? 16'hFFFF :
			16'(HEADER_BYTES + plen + $urandom_range(0, 30));
		h.now_time_us = clock_us;
		return h;
	endfunction

	function automatic frag_hdr_t sweep(logic [63:0] at);
		frag_hdr_t h;
		h = frag($urandom, 1, 0);
		h.cmd = 1'b1;
		h.now_time_us = at;
		return h;
	endfunction

	function automatic frag_hdr_t noise();
		frag_hdr_t h;
		h = '{1'b0, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), $urandom, 16'($urandom), 16'($urandom), rand64(),
			16'($urandom), rand64()};
		h.cmd = ($urandom_range(9) == 0);
		if ($urandom_range(1)) h.hdr_version = cur_ver;
		if ($urandom_range(1)) h.total_frags = 16'($urandom_range(0, 40));
		if ($urandom_range(1)) h.frag_num = 16'($urandom_range(0, 40));
		return h;
	endfunction

	// a few interleaved frames in shuffled order, with gaps, repeats and noise
	task automatic burst();
		frag_hdr_t order[$];
		frag_hdr_t lane[3][$];
		int nfr, tot, j, t, pick;
		int perm[MAX_FRAGS];
		logic [31:0] fr;
		nfr = $urandom_range(1, 3);
		for (int f = 0; f < nfr; f++) begin
			fr = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 40);
			tot = ($urandom_range(14) == 0) ? $urandom_range(6, 32) : $urandom_range(1, 5);
			for (int i = 0; i < tot; i++) perm[i] = i;
			for (int i = tot - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = perm[i];
				perm[i] = perm[j];
				perm[j] = t;
			end
			for (int i = 0; i < tot; i++) begin
				if ($urandom_range(19) != 0) lane[f].push_back(frag(fr, tot, perm[i]));
				if ($urandom_range(11) == 0) lane[f].push_back(frag(fr, tot, perm[i]));
			end
		end
		while (lane[0].size() + lane[1].size() + lane[2].size() != 0) begin
			pick = $urandom_range(0, nfr - 1);
			if (lane[pick].size() != 0) order.push_back(lane[pick].pop_front());
		end
		foreach (order[i]) begin
			if ($urandom_range(9) == 0) send(noise());
			send(order[i]);
		end
		if ($urandom_range(7) == 0) send(sweep(clock_us));
	endtask

	task run_phase(int items);
		int stop_at;
		stop_at = sent + items;
		while (sent < stop_at) begin
			// occasionally step time back so a new frame can lose its own eviction
			if ($urandom_range(15) == 0) clock_us -= $urandom_range(0, 20000);
			burst();
		end
	endtask

	initial begin
		frag_hdr_t h;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIRE_VERSION;
		cfg_data = '0;
		hdr.valid = 1'b0;
		hdr.cmd = 1'b0;
		hdr.hdr_version = '0;
		hdr.frame_type = '0;
		hdr.hdr_flags = '0;
		hdr.stream_num = '0;
		hdr.total_frags = '0;
		hdr.frame_num = '0;
		hdr.frag_num = '0;
		hdr.payload_bytes = '0;
		hdr.capture_time_us = '0;
		hdr.datagram_bytes = '0;
		hdr.now_time_us = '0;
		res.ready = 1'b0;
		hold_req = 0;
		hold_left = 0;
		quiet_cycles = 0;
		sent = 0;
		offering = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cur_ver = 8'd1;
		clock_us = 64'd1000;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: each header-check drop reason
		h = frag(32'd7, 2, 0); h.datagram_bytes = 16'd23; h.payload_bytes = '0; send(h);
		h = frag(32'd7, 2, 0); h.hdr_version = 8'd2; send(h);
		h = frag(32'd7, 0, 0); send(h);
		h = frag(32'd7, 2, 2); send(h);
		h = frag(32'd7, 33, 0); send(h);
		h = frag(32'd7, 2, 0); h.payload_bytes = h.datagram_bytes - 16'd23; send(h);
		// largest single-fragment frame, with frame number, type, flags, stream, capture time and lengths at their maximum
		h = frag(32'hFFFFFFFF, 1, 0);
		h.frame_type = 8'hFF; h.hdr_flags = 16'hFFFF; h.stream_num = 16'hFFFF;
		h.capture_time_us = '1; h.payload_bytes = 16'd65511; h.datagram_bytes = 16'hFFFF;
		send(h);
		// duplicate, then a count mismatch that frees the entry
		send(frag(32'd0, 3, 1));
		send(frag(32'd0, 3, 1));
		send(frag(32'd0, 4, 2));
		// full 32-fragment frame, reverse order
		for (int i = MAX_FRAGS - 1; i >= 0; i--) begin
			h = frag(32'd9, MAX_FRAGS, i);
			if (i != 5) h.hdr_flags[0] = 1'b0;
			send(h);
		end
		// sweep across a wrapping clock
		h = frag(32'd11, 2, 0); h.now_time_us = 64'hFFFFFFFFFFFFFFF0; send(h);
		send(sweep(64'd5));
		send(sweep(64'd600000));
		drain();

		// phase 0: reset settings, long result hold-off, first with no idling, then with idling
		hold_req = 600;
		run_phase(40);
		drain();
		send_idle_pct = 51;
		run_phase(30);
		drain();

		// phase 1: minimum version, timeout and limit, full key mask, single pending slot
		write_regs(32'd0, 32'hFFFF, 32'd0, 32'd1);
		send_idle_pct = 0;
		recv_stall_pct = 51;
		run_phase(60);
		drain();

		// phase 2: maximum version and timeout, empty key mask, limit of 0 treated as one
		write_regs(32'd255, 32'd0, 32'hFFFFFFFF, 32'd0);
		send_idle_pct = 34;
		recv_stall_pct = 34;
		run_phase(50);
		drain();

		// phase 3: limit above the table depth, short timeout
		write_regs($urandom_range(0, 255), $urandom, 32'd5000, 32'd31);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_phase(40);
		drain();

		// phase 4: a few slots, mixed idling
		write_regs(32'd1, 32'h8001, 32'd20000, 32'd4);
		send_idle_pct = 34;
		recv_stall_pct = 34;
		hold_req = 300;
		run_phase(50);

		drain();
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
